@@ rtl/u8rx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8rx_pkg
// shared types and constants of the 8n1 receiver with receive fifo
// ----------------------------------------------------------------------------
package u8rx_pkg;

  // receive fifo, holds FIFO_DEPTH-1 bytes
  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // serial framing
  localparam int          DATA_BITS  = 8;
  localparam logic [3:0]  LAST_BIT   = 4'(DATA_BITS);
  localparam logic [15:0] MIN_PERIOD = 16'd4;
  localparam logic [15:0] RST_PERIOD = 16'd434;

  // configuration register index (paddr[2])
  localparam logic REG_BIT_PERIOD = 1'b0;

  typedef enum logic [1:0] {
    RX_IDLE  = 2'd0,
    RX_START = 2'd1,
    RX_DATA  = 2'd2,
    RX_STOP  = 2'd3
  } rx_state_t;

  // deframer to fifo control
  typedef struct packed {
    logic       done;
    logic [7:0] data;
  } frame_t;

endpackage

@@ rtl/uart_8n1_receiver_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8n1_receiver_fifo
// 8n1 serial receiver with a receive ring fifo, one line sample per word
// ----------------------------------------------------------------------------
// the result word is registered and valid in the cycle after its input word is accepted
// throughput: one word per cycle while m_tready keeps the output register free, set by
//   the single register stage between the line sampler / fifo pointers and the output register
// reset (rst, synchronous): receiver idle, fifo empty, bit period 434, no
//   result pending; fifo byte storage is not cleared, no clearing pass
// ----------------------------------------------------------------------------
module uart_8n1_receiver_fifo
  import u8rx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] rx_level, [1] pop_request, rest zero
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] read_data, [8] data_available,
                                 // [9] byte_received, [10] overflow, rest zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [15:0] bit_period_ticks;
  logic [15:0] period;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period_ticks <= RST_PERIOD;
    end else if (cfg_write && paddr[2] == REG_BIT_PERIOD) begin
      bit_period_ticks <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BIT_PERIOD) begin
      prdata = {16'd0, bit_period_ticks};
    end
  end

  // very short periods are clamped so the half-bit wait is never zero
  assign period = (bit_period_ticks < MIN_PERIOD) ? MIN_PERIOD : bit_period_ticks;

  // --------------------------------------------------------------------------
  // input handshake: the output register frees up when its word is taken
  // --------------------------------------------------------------------------
  logic s_acc;
  logic rx_level;
  logic pop_request;

  assign s_tready    = !m_tvalid || m_tready;
  assign s_acc       = s_tvalid && s_tready;
  assign rx_level    = s_tdata[0];
  assign pop_request = s_tdata[1];

  // --------------------------------------------------------------------------
  // line deframer
  // --------------------------------------------------------------------------
  frame_t frame;

  u8rx_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .advance (s_acc),
    .level   (rx_level),
    .period  (period),
    .frame   (frame)
  );

  // --------------------------------------------------------------------------
  // ring fifo: pop is served first from the old contents, then a finished
  // byte may take the slot the pop just freed
  // --------------------------------------------------------------------------
  logic [7:0]       fifo_store [FIFO_DEPTH];
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [PTR_W-1:0] wp_inc, rp_inc;
  logic             pop_ok, push_ok, drop;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign rp_inc = ring_next(read_pointer);
  assign wp_inc = ring_next(write_pointer);

  always_comb begin
    pop_ok             = pop_request && (read_pointer != write_pointer);
    read_pointer_next  = pop_ok ? rp_inc : read_pointer;
    // full is judged against the pointer after this word's pop
    push_ok            = frame.done && (wp_inc != read_pointer_next);
    drop               = frame.done && (wp_inc == read_pointer_next);
    write_pointer_next = push_ok ? wp_inc : write_pointer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
    end else if (s_acc) begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
    end
  end

  // storage: write at write_pointer, registered read at read_pointer; a
  // popped slot never equals the slot written in the same word
  logic [7:0] rd_q;

  always_ff @(posedge clk) begin
    if (s_acc && push_ok) begin
      fifo_store[write_pointer] <= frame.data;
    end
    if (s_acc) begin
      rd_q <= fifo_store[read_pointer];
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic res_pop, res_avail, res_got, res_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      res_pop   <= pop_ok;
      res_avail <= (write_pointer_next != read_pointer_next);
      res_got   <= push_ok;
      res_ovf   <= drop;
    end
  end

  // read_data reads zero when nothing was popped
  assign m_tdata = {5'd0, res_ovf, res_got, res_avail, (res_pop ? rd_q : 8'd0)};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a finished byte is either stored or dropped, never both
  a_got_xor_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res_got && res_ovf))
    else $error("byte both stored and dropped");

  // a stored byte leaves the fifo nonempty
  a_got_avail: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_got) |-> res_avail)
    else $error("byte stored but fifo reads empty");

  // a pop on an empty fifo leaves the read pointer alone
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (s_acc && pop_request && read_pointer == write_pointer) |=>
      $stable(read_pointer))
    else $error("read pointer moved on empty pop");

  // no result is pending right after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

@@ rtl/u8rx_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8rx_deframer
// start / data / stop bit timing and data shift register, one tick per word
// ----------------------------------------------------------------------------
module u8rx_deframer
  import u8rx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        level,
  input  logic [15:0] period,
  output frame_t      frame
);

  rx_state_t   state, state_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;
  logic        done;

  assign tick_inc = tick_count + 16'd1;
  assign bit_inc  = bit_index + 4'd1;

  always_comb begin
    state_next      = state;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    done            = 1'b0;
    unique case (state)
      RX_IDLE: begin
        if (!level) begin
          state_next      = RX_START;
          tick_count_next = '0;
          bit_index_next  = '0;
          shift_byte_next = '0;
        end
      end
      RX_START: begin
        tick_count_next = tick_inc;
        // middle of the start bit
        if (tick_inc >= {1'b0, period[15:1]}) begin
          state_next      = RX_DATA;
          tick_count_next = '0;
        end
      end
      RX_DATA: begin
        tick_count_next = tick_inc;
        if (tick_inc >= period) begin
          tick_count_next = '0;
          shift_byte_next = {level, shift_byte[7:1]};
          bit_index_next  = bit_inc;
          if (bit_inc >= LAST_BIT) begin
            bit_index_next = '0;
            state_next     = RX_STOP;
          end
        end
      end
      RX_STOP: begin
        tick_count_next = tick_inc;
        // stop level is not checked
        if (tick_inc >= period) begin
          tick_count_next = '0;
          state_next      = RX_IDLE;
          done            = 1'b1;
        end
      end
      default: state_next = RX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= RX_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
    end else if (advance) begin
      state      <= state_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
    end
  end

  assign frame.done = done;
  assign frame.data = shift_byte;

endmodule
